// ----- design/assert_macros.svh -----
// Assertion helpers shared by the line editor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define ATE_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define ATE_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- design/ate_pkg.sv -----
package ate_pkg;

  localparam int MAX_RESULTS = 42;

  // Byte codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_UP_C  = 8'h43;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_LO_S  = 8'h73;
  localparam logic [7:0] CH_LO_U  = 8'h75;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_INS, ACT_BS, ACT_CR, ACT_MOVE, ACT_DELF
  } act_e;

  typedef enum logic [2:0] {
    EM_CONST, EM_RX, EM_MEM, EM_D2, EM_D1, EM_D0, EM_DIR
  } emsel_e;

  typedef struct packed {
    logic       load;
    logic       dec;
    logic       emit;
    emsel_e     sel;
    logic [7:0] ebyte;
    logic       kind;
    logic       mem_rd;
    logic       rd_next;
    logic       mem_wr;
    logic       wr_rdata;
    logic       step;
    logic       carry_ld;
    logic       flush;
  } ate_cmd_t;

  typedef struct packed {
    act_e act;
    logic cnt_zero;
    logic cnt_one;
    logic echo;
    logic ge100;
    logic ge10;
    logic emit_rdy;
  } ate_sts_t;

  // Binary to three decimal digits (hundreds in the top nibble)
  function automatic logic [11:0] to_dec(input logic [7:0] n);
    logic [19:0] s;
    s = {12'd0, n};
    for (int i = 0; i < 8; i++) begin
      if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
      if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
      if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
      s = s << 1;
    end
    return s[19:8];
  endfunction

endpackage

// ----- design/ate_datapath.sv -----
module ate_datapath #(
  parameter int LINE_LEN = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ate_pkg::ate_cmd_t cmd_i,
  output ate_pkg::ate_sts_t sts_o,
  input  logic [7:0]        rx_data_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_data_i,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  output logic [7:0]        m_tdata_o,
  output logic              m_tuser_o,
  output logic              m_tlast_o
);
  import ate_pkg::*;

  localparam int AW = $clog2(LINE_LEN);
  localparam int CW = AW;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ESC   = 3'd1;
  localparam logic [2:0] PH_FIRST = 3'd2;
  localparam logic [2:0] PH_VAL   = 3'd3;
  localparam logic [2:0] PH_VAL2  = 3'd4;

  logic [7:0]    line_mem_q [LINE_LEN];
  logic [7:0]    rdata_q;
  logic [7:0]    rx_q;
  logic          echo_q;
  logic [CW-1:0] cur_q, cur_d, tail_q, tail_d;
  logic [2:0]    phase_q, phase_d;
  logic [7:0]    v1_q, v1_d, v2_q, v2_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    carry_q, carry_d, mvn_q, mvn_d, mvdir_q, mvdir_d;
  logic          pend_v_q, pend_k_q, out_v_q, out_k_q, out_l_q;
  logic [7:0]    pend_b_q, out_b_q;
  logic [5:0]    ecnt_q;

  // Decode of the latched byte
  logic       dig, in_seq, run;
  logic [3:0] dval;
  logic [7:0] v_eff, cur8, tail8;
  logic [CW:0] len;
  act_e       act;
  logic [11:0] acc1, acc2, dec_digits;

  assign dig    = (rx_q >= CH_ZERO) && (rx_q <= CH_NINE);
  assign dval   = 4'(rx_q - CH_ZERO);
  assign in_seq = (phase_q == PH_FIRST) || (phase_q == PH_VAL) || (phase_q == PH_VAL2);
  assign v_eff  = (phase_q == PH_FIRST) ? 8'd1 : v1_q;
  assign cur8   = 8'(cur_q);
  assign tail8  = 8'(tail_q);
  assign len    = {1'b0, cur_q} + {1'b0, tail_q};
  assign acc1   = {4'd0, v1_q} * 12'd10 + {8'd0, dval};
  assign acc2   = {4'd0, v2_q} * 12'd10 + {8'd0, dval};
  assign run    = in_seq && !dig &&
                  !((rx_q == CH_SEMI) && (phase_q == PH_VAL));

  always_comb begin
    act = ACT_NONE;
    if (run) begin
      case (rx_q)
        CH_UP_D: if (v_eff <= cur8)  act = ACT_MOVE;
        CH_UP_C: if (v_eff <= tail8) act = ACT_MOVE;
        CH_UP_H: if (cur_q != '0)    act = ACT_MOVE;
        CH_UP_F: if (tail_q != '0)   act = ACT_MOVE;
        CH_TILDE: if (tail_q != '0)  act = ACT_DELF;
        default: act = ACT_NONE;
      endcase
    end else if (!in_seq && phase_q != PH_ESC) begin
      if (rx_q == CH_DEL) begin
        if (cur_q != '0) act = ACT_BS;
      end else if (rx_q == CH_CR) begin
        act = ACT_CR;
      end else if (rx_q >= CH_SPACE && rx_q <= CH_TILDE &&
                   len < (CW+1)'(LINE_LEN - 1)) begin
        act = ACT_INS;
      end
    end
  end

  // Next state of the editor registers
  always_comb begin
    cur_d = cur_q; tail_d = tail_q; phase_d = phase_q;
    v1_d = v1_q; v2_d = v2_q; idx_d = idx_q; cnt_d = cnt_q;
    carry_d = carry_q; mvn_d = mvn_q; mvdir_d = mvdir_q;
    if (cmd_i.dec) begin
      // sequence and phase tracking
      if (in_seq) begin
        if (run) begin
          phase_d = PH_IDLE;
          if (phase_q == PH_FIRST) v1_d = 8'd1;
        end else if (phase_q == PH_FIRST) begin
          phase_d = PH_VAL;
          v1_d = 8'(dval);
          v2_d = 8'd0;
        end else if (dig) begin
          if (phase_q == PH_VAL2) v2_d = (acc2 > 12'd255) ? 8'd255 : acc2[7:0];
          else v1_d = (acc1 > 12'd255) ? 8'd255 : acc1[7:0];
        end else begin
          phase_d = PH_VAL2;
        end
      end else if (phase_q == PH_ESC) begin
        phase_d = (rx_q == CH_LBRK) ? PH_FIRST : PH_IDLE;
      end else begin
        phase_d = (rx_q == CH_ESC) ? PH_ESC : PH_IDLE;
      end
      // line edits
      case (act)
        ACT_MOVE: begin
          case (rx_q)
            CH_UP_D: begin
              tail_d = tail_q + v_eff[CW-1:0]; cur_d = cur_q - v_eff[CW-1:0];
              mvn_d = v_eff; mvdir_d = CH_UP_D;
            end
            CH_UP_C: begin
              tail_d = tail_q - v_eff[CW-1:0]; cur_d = cur_q + v_eff[CW-1:0];
              mvn_d = v_eff; mvdir_d = CH_UP_C;
            end
            CH_UP_H: begin
              tail_d = tail_q + cur_q; cur_d = '0; mvn_d = cur8; mvdir_d = CH_UP_D;
            end
            default: begin
              cur_d = cur_q + tail_q; tail_d = '0; mvn_d = tail8; mvdir_d = CH_UP_C;
            end
          endcase
        end
        ACT_DELF: begin
          mvn_d = 8'd1; mvdir_d = CH_UP_C;
          tail_d = tail_q - 1'b1;
          idx_d = AW'(cur_q); cnt_d = tail_q - 1'b1;
        end
        ACT_BS: begin
          cur_d = cur_q - 1'b1;
          idx_d = AW'(cur_q - 1'b1); cnt_d = tail_q;
        end
        ACT_CR: begin
          idx_d = '0; cnt_d = len[CW-1:0]; cur_d = '0; tail_d = '0;
        end
        ACT_INS: begin
          idx_d = AW'(cur_q); cnt_d = tail_q; carry_d = rx_q; cur_d = cur_q + 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd_i.step) begin
      idx_d = idx_q + 1'b1;
      cnt_d = cnt_q - 1'b1;
    end
    if (cmd_i.carry_ld) carry_d = rdata_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0; tail_q <= '0; phase_q <= PH_IDLE;
      v1_q <= '0; v2_q <= '0; echo_q <= 1'b1;
    end else begin
      cur_q <= cur_d; tail_q <= tail_d; phase_q <= phase_d;
      v1_q <= v1_d; v2_q <= v2_d;
      if (cfg_valid_i) echo_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) rx_q <= rx_data_i;
    idx_q <= idx_d; cnt_q <= cnt_d; carry_q <= carry_d;
    mvn_q <= mvn_d; mvdir_q <= mvdir_d;
  end

  // Line memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) line_mem_q[idx_q] <= cmd_i.wr_rdata ? rdata_q : carry_q;
    if (cmd_i.mem_rd) rdata_q <= line_mem_q[cmd_i.rd_next ? idx_q + 1'b1 : idx_q];
  end

  // Emit byte select
  logic [7:0] em_byte;
  assign dec_digits = to_dec(mvn_q);
  always_comb begin
    case (cmd_i.sel)
      EM_RX:   em_byte = rx_q;
      EM_MEM:  em_byte = rdata_q;
      EM_D2:   em_byte = CH_ZERO + 8'(dec_digits[11:8]);
      EM_D1:   em_byte = CH_ZERO + 8'(dec_digits[7:4]);
      EM_D0:   em_byte = CH_ZERO + 8'(dec_digits[3:0]);
      EM_DIR:  em_byte = mvdir_q;
      default: em_byte = cmd_i.ebyte;
    endcase
  end

  // One byte held back so the final one of an item can carry tlast
  logic emit_rdy;
  assign emit_rdy = !pend_v_q || !out_v_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0; out_v_q <= 1'b0; ecnt_q <= '0;
    end else begin
      if (out_v_q && m_tready_i) out_v_q <= 1'b0;
      if (cmd_i.emit && emit_rdy && ecnt_q < 6'(MAX_RESULTS)) begin
        ecnt_q <= ecnt_q + 1'b1;
        pend_v_q <= 1'b1;
        if (pend_v_q) out_v_q <= 1'b1;
      end else if (cmd_i.flush && emit_rdy) begin
        ecnt_q <= '0;
        pend_v_q <= 1'b0;
        if (pend_v_q) out_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && emit_rdy && ecnt_q < 6'(MAX_RESULTS)) begin
      pend_b_q <= em_byte; pend_k_q <= cmd_i.kind;
      if (pend_v_q) begin
        out_b_q <= pend_b_q; out_k_q <= pend_k_q; out_l_q <= 1'b0;
      end
    end else if (cmd_i.flush && emit_rdy && pend_v_q) begin
      out_b_q <= pend_b_q; out_k_q <= pend_k_q; out_l_q <= 1'b1;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_b_q;
  assign m_tuser_o  = out_k_q;
  assign m_tlast_o  = out_l_q;

  assign sts_o.act      = act;
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.cnt_one  = (cnt_q == CW'(1));
  assign sts_o.echo     = echo_q;
  assign sts_o.ge100    = (mvn_q >= 8'd100);
  assign sts_o.ge10     = (mvn_q >= 8'd10);
  assign sts_o.emit_rdy = emit_rdy;

`include "assert_macros.svh"
  `ATE_ASSERT_SAME(a_ecnt_cap, 1'b1, ecnt_q <= 6'(MAX_RESULTS), "result count past limit")
  `ATE_ASSERT_SAME(a_len_fits, 1'b1, len < (CW+1)'(LINE_LEN), "line longer than store")
  `ATE_ASSERT_NEXT(a_flush_empty, cmd_i.flush && emit_rdy && !cmd_i.emit, !pend_v_q,
                   "held byte not released")

endmodule

// ----- design/ate_ctrl.sv -----
module ate_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ate_pkg::ate_sts_t sts_i,
  output ate_pkg::ate_cmd_t cmd_o
);
  import ate_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DEC   = 5'd1;
  localparam logic [4:0] S_MV0   = 5'd2;
  localparam logic [4:0] S_MV1   = 5'd3;
  localparam logic [4:0] S_MV2   = 5'd4;
  localparam logic [4:0] S_MV3   = 5'd5;
  localparam logic [4:0] S_MV4   = 5'd6;
  localparam logic [4:0] S_MV5   = 5'd7;
  localparam logic [4:0] S_ER0   = 5'd8;
  localparam logic [4:0] S_ER1   = 5'd9;
  localparam logic [4:0] S_ER2   = 5'd10;
  localparam logic [4:0] S_ERRD  = 5'd11;
  localparam logic [4:0] S_ERWR  = 5'd12;
  localparam logic [4:0] S_ERSP  = 5'd13;
  localparam logic [4:0] S_INS   = 5'd14;
  localparam logic [4:0] S_INRD  = 5'd15;
  localparam logic [4:0] S_INWR  = 5'd16;
  localparam logic [4:0] S_CR0   = 5'd17;
  localparam logic [4:0] S_CR1   = 5'd18;
  localparam logic [4:0] S_CRRD  = 5'd19;
  localparam logic [4:0] S_CREM  = 5'd20;
  localparam logic [4:0] S_CRZ   = 5'd21;
  localparam logic [4:0] S_SQ0   = 5'd22;
  localparam logic [4:0] S_SQ1   = 5'd23;
  localparam logic [4:0] S_SQ2   = 5'd24;
  localparam logic [4:0] S_FLUSH = 5'd25;

  logic [4:0] state_q, state_d, ret_q, ret_d;
  logic [7:0] fin_q, fin_d;
  act_e       act_q, act_d;
  logic       rdy;

  assign rdy        = sts_i.emit_rdy;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q; ret_d = ret_q; fin_d = fin_q; act_d = act_q;
    cmd_o = '0;
    cmd_o.sel = EM_CONST;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        act_d = sts_i.act;
        case (sts_i.act)
          ACT_INS:  state_d = S_INS;
          ACT_BS:   state_d = S_ER0;
          ACT_CR:   state_d = S_CR0;
          ACT_MOVE: state_d = S_MV0;
          ACT_DELF: state_d = S_MV0;
          default:  state_d = S_FLUSH;
        endcase
      end
      // cursor move sequence with decimal count
      S_MV0: begin
        cmd_o.emit = 1'b1; cmd_o.ebyte = CH_ESC;
        if (rdy) state_d = S_MV1;
      end
      S_MV1: begin
        cmd_o.emit = 1'b1; cmd_o.ebyte = CH_LBRK;
        if (rdy) state_d = sts_i.ge100 ? S_MV2 : (sts_i.ge10 ? S_MV3 : S_MV4);
      end
      S_MV2: begin
        cmd_o.emit = 1'b1; cmd_o.sel = EM_D2;
        if (rdy) state_d = S_MV3;
      end
      S_MV3: begin
        cmd_o.emit = 1'b1; cmd_o.sel = EM_D1;
        if (rdy) state_d = S_MV4;
      end
      S_MV4: begin
        cmd_o.emit = 1'b1; cmd_o.sel = EM_D0;
        if (rdy) state_d = S_MV5;
      end
      S_MV5: begin
        cmd_o.emit = 1'b1; cmd_o.sel = EM_DIR;
        if (rdy) state_d = (act_q == ACT_DELF) ? S_ER0 : S_FLUSH;
      end
      // erase one character and redraw the tail
      S_ER0: begin
        cmd_o.emit = 1'b1; cmd_o.ebyte = CH_BS;
        if (rdy) begin
          if (sts_i.cnt_zero) begin
            state_d = S_ER1;
          end else begin
            fin_d = CH_LO_S; ret_d = S_ERRD; state_d = S_SQ0;
          end
        end
      end
      S_ER1: begin
        cmd_o.emit = 1'b1; cmd_o.ebyte = CH_SPACE;
        if (rdy) state_d = S_ER2;
      end
      S_ER2: begin
        cmd_o.emit = 1'b1; cmd_o.ebyte = CH_BS;
        if (rdy) state_d = S_FLUSH;
      end
      S_ERRD: begin
        cmd_o.mem_rd = 1'b1; cmd_o.rd_next = 1'b1;
        state_d = S_ERWR;
      end
      S_ERWR: begin
        cmd_o.emit = 1'b1; cmd_o.sel = EM_MEM;
        if (rdy) begin
          cmd_o.mem_wr = 1'b1; cmd_o.wr_rdata = 1'b1; cmd_o.step = 1'b1;
          state_d = sts_i.cnt_one ? S_ERSP : S_ERRD;
        end
      end
      S_ERSP: begin
        cmd_o.emit = 1'b1; cmd_o.ebyte = CH_SPACE;
        if (rdy) begin
          fin_d = CH_LO_U; ret_d = S_FLUSH; state_d = S_SQ0;
        end
      end
      // insert at the cursor, shifting the tail up
      S_INS: begin
        cmd_o.emit = sts_i.echo; cmd_o.sel = EM_RX;
        if (rdy || !sts_i.echo) begin
          if (sts_i.cnt_zero) begin
            cmd_o.mem_wr = 1'b1;
            state_d = S_FLUSH;
          end else begin
            fin_d = CH_LO_S; ret_d = S_INRD; state_d = S_SQ0;
          end
        end
      end
      S_INRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_INWR;
      end
      S_INWR: begin
        if (sts_i.cnt_zero) begin
          cmd_o.mem_wr = 1'b1;
          fin_d = CH_LO_U; ret_d = S_FLUSH; state_d = S_SQ0;
        end else begin
          cmd_o.emit = 1'b1; cmd_o.sel = EM_MEM;
          if (rdy) begin
            cmd_o.mem_wr = 1'b1; cmd_o.carry_ld = 1'b1; cmd_o.step = 1'b1;
            state_d = S_INRD;
          end
        end
      end
      // line complete: CR LF then the line and a terminator
      S_CR0: begin
        cmd_o.emit = 1'b1; cmd_o.ebyte = CH_CR;
        if (rdy) state_d = S_CR1;
      end
      S_CR1: begin
        cmd_o.emit = 1'b1; cmd_o.ebyte = CH_LF;
        if (rdy) state_d = S_CRRD;
      end
      S_CRRD: begin
        if (sts_i.cnt_zero) begin
          state_d = S_CRZ;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = S_CREM;
        end
      end
      S_CREM: begin
        cmd_o.emit = 1'b1; cmd_o.sel = EM_MEM; cmd_o.kind = 1'b1;
        if (rdy) begin
          cmd_o.step = 1'b1;
          state_d = S_CRRD;
        end
      end
      S_CRZ: begin
        cmd_o.emit = 1'b1; cmd_o.ebyte = CH_NUL; cmd_o.kind = 1'b1;
        if (rdy) state_d = S_FLUSH;
      end
      // three-byte control sequence ESC [ final
      S_SQ0: begin
        cmd_o.emit = 1'b1; cmd_o.ebyte = CH_ESC;
        if (rdy) state_d = S_SQ1;
      end
      S_SQ1: begin
        cmd_o.emit = 1'b1; cmd_o.ebyte = CH_LBRK;
        if (rdy) state_d = S_SQ2;
      end
      S_SQ2: begin
        cmd_o.emit = 1'b1; cmd_o.ebyte = fin_q;
        if (rdy) state_d = ret_q;
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (rdy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      act_q   <= ACT_NONE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      act_q   <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
  end

`include "assert_macros.svh"
  `ATE_ASSERT_NEXT(a_load_dec, cmd_o.load, state_q == S_DEC, "decode skipped")
  `ATE_ASSERT_NEXT(a_flush_idle, state_q == S_FLUSH && rdy, state_q == S_IDLE,
                   "no return to idle after flush")
  `ATE_ASSERT_SAME(a_wr_gated, cmd_o.step, rdy, "step without output room")

endmodule

// ----- design/ansi_terminal_line_editor.sv -----
// Line editor for a serial terminal.
// s_axis carries received bytes (tdata = rx_byte). m_axis carries results:
// tdata = out_byte, tuser = out_kind (0 echo to terminal, 1 line byte),
// tlast marks the final result of the received byte. Bytes that cause no
// result produce no m_axis transfer at all.
// cfg_valid_i/cfg_data_i write echo_enable (reset 1); cfg_ready_o is always 1.
// One byte is handled at a time: s_axis_tready is high only while idle.
// Every line character is read from the line memory and then, in a
// separate state, written or emitted. Reset empties the line and clears
// escape parsing; store contents are not cleared and need no sweep.
// When m_axis_tready is low the sequencer halts in place with one result
// held back, so nothing is lost or repeated.
module ansi_terminal_line_editor #(
  parameter int LINE_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] out_kind
  output logic       m_axis_tlast,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);
  import ate_pkg::*;

  ate_cmd_t cmd;
  ate_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ate_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ate_datapath #(
    .LINE_LEN (LINE_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rx_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .m_tlast_o   (m_axis_tlast)
  );

endmodule

// ----- dv/ansi_terminal_line_editor_checker.sv -----
`timescale 1ns / 100ps

// Watches both streams and the echo register write channel, predicts the
// editor's output bytes and compares them in order.
module ansi_terminal_line_editor_checker #(
  parameter int LINE_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  input  logic       m_axis_tuser,
  input  logic       m_axis_tlast,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_o,
  input  logic       cfg_data_i,
  output int         err_cnt_o,
  output int         pending_o,
  output int         result_cnt_o
);
  import ate_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ESC  = 3'd1;
  localparam logic [2:0] PH_LEAD = 3'd2;
  localparam logic [2:0] PH_VAL  = 3'd3;
  localparam logic [2:0] PH_VAL2 = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       last;
  } out_item_t;

  // predicted editor state
  logic [7:0] line_q [LINE_LEN];
  logic [5:0] cur_q;
  logic [5:0] tail_q;
  logic [2:0] phase_q;
  logic [7:0] val1_q;
  logic [7:0] val2_q;
  logic       echo_q;

  out_item_t  step_q [$];
  out_item_t  expected_q [$];

  function automatic void push_byte(input logic [7:0] b, input logic k);
    out_item_t it;
    it.data = b;
    it.kind = k;
    it.last = 1'b0;
    if (step_q.size() < MAX_RESULTS) step_q.push_back(it);
  endfunction

  function automatic void push_csi(input logic [7:0] fin);
    push_byte(CH_ESC, 1'b0);
    push_byte(CH_LBRK, 1'b0);
    push_byte(fin, 1'b0);
  endfunction

  function automatic void push_move(input int n, input logic [7:0] dir);
    push_byte(CH_ESC, 1'b0);
    push_byte(CH_LBRK, 1'b0);
    if (n >= 100) push_byte(CH_ZERO + 8'((n / 100) % 10), 1'b0);
    if (n >= 10) push_byte(CH_ZERO + 8'((n / 10) % 10), 1'b0);
    push_byte(CH_ZERO + 8'(n % 10), 1'b0);
    push_byte(dir, 1'b0);
  endfunction

  // remove character at p, pull tail of t down and redraw it
  function automatic void erase_char(input int p, input int t);
    push_byte(CH_BS, 1'b0);
    if (t == 0) begin
      push_byte(CH_SPACE, 1'b0);
      push_byte(CH_BS, 1'b0);
    end else begin
      push_csi(CH_LO_S);
      for (int i = 0; i < t; i++) begin
        if (p + i + 1 < LINE_LEN && p + i < LINE_LEN) line_q[p + i] = line_q[p + i + 1];
        push_byte((p + i < LINE_LEN) ? line_q[p + i] : 8'h00, 1'b0);
      end
      push_byte(CH_SPACE, 1'b0);
      push_csi(CH_LO_U);
    end
  endfunction

  function automatic logic [7:0] add_digit(input logic [7:0] v, input logic [7:0] b);
    int r;
    r = int'(v) * 10 + int'(b - CH_ZERO);
    return (r > 255) ? 8'd255 : 8'(r);
  endfunction

  function automatic void run_command(input logic [7:0] b);
    int v;
    v = int'(val1_q);
    case (b)
      CH_UP_D: begin
        if (v <= int'(cur_q)) begin
          tail_q = tail_q + 6'(v);
          cur_q = cur_q - 6'(v);
          push_move(v, CH_UP_D);
        end
      end
      CH_UP_C: begin
        if (v <= int'(tail_q)) begin
          tail_q = tail_q - 6'(v);
          cur_q = cur_q + 6'(v);
          push_move(v, CH_UP_C);
        end
      end
      CH_UP_H: begin
        if (cur_q != '0) begin
          push_move(int'(cur_q), CH_UP_D);
          tail_q = tail_q + cur_q;
          cur_q = '0;
        end
      end
      CH_UP_F: begin
        if (tail_q != '0) begin
          push_move(int'(tail_q), CH_UP_C);
          cur_q = cur_q + tail_q;
          tail_q = '0;
        end
      end
      CH_TILDE: begin
        if (tail_q != '0) begin
          push_move(1, CH_UP_C);
          tail_q = tail_q - 6'd1;
          erase_char(int'(cur_q), int'(tail_q));
        end
      end
      default: ;
    endcase
    phase_q = PH_IDLE;
  endfunction

  function automatic void edit_byte(input logic [7:0] b);
    logic dig;
    int p, t;
    step_q.delete();
    dig = (b >= CH_ZERO && b <= CH_NINE);
    if (phase_q >= PH_LEAD && phase_q <= PH_VAL2) begin
      if (phase_q == PH_LEAD) begin
        if (!dig) begin
          val1_q = 8'd1;
          run_command(b);
        end else begin
          phase_q = PH_VAL;
          val1_q = b - CH_ZERO;
          val2_q = 8'd0;
        end
      end else if (dig) begin
        if (phase_q == PH_VAL2) val2_q = add_digit(val2_q, b);
        else val1_q = add_digit(val1_q, b);
      end else if (b == CH_SEMI && phase_q == PH_VAL) begin
        phase_q = PH_VAL2;
      end else begin
        run_command(b);
      end
    end else if (phase_q == PH_ESC) begin
      phase_q = (b == CH_LBRK) ? PH_LEAD : PH_IDLE;
    end else begin
      phase_q = PH_IDLE;
      if (b < CH_SPACE || b > CH_TILDE) begin
        if (b == CH_DEL) begin
          if (cur_q > 6'd0) begin
            cur_q = cur_q - 6'd1;
            erase_char(int'(cur_q), int'(tail_q));
          end
        end else if (b == CH_ESC) begin
          phase_q = PH_ESC;
        end else if (b == CH_CR) begin
          push_byte(CH_CR, 1'b0);
          push_byte(CH_LF, 1'b0);
          for (int i = 0; i < int'(cur_q) + int'(tail_q); i++) push_byte(line_q[i], 1'b1);
          push_byte(CH_NUL, 1'b1);
          cur_q = '0;
          tail_q = '0;
        end
      end else if (int'(cur_q) + int'(tail_q) < LINE_LEN - 1) begin
        p = int'(cur_q);
        t = int'(tail_q);
        if (echo_q) push_byte(b, 1'b0);
        if (t != 0) begin
          for (int i = t; i > 0; i--) line_q[p + i] = line_q[p + i - 1];
          line_q[p] = b;
          push_csi(CH_LO_S);
          for (int i = 1; i <= t; i++) push_byte(line_q[p + i], 1'b0);
          push_csi(CH_LO_U);
        end else begin
          line_q[p] = b;
        end
        cur_q = 6'(p + 1);
      end
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      cur_q = '0;
      tail_q = '0;
      phase_q = PH_IDLE;
      val1_q = '0;
      val2_q = '0;
      echo_q = 1'b1;
      expected_q.delete();
      err_cnt_o <= 0;
      result_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      // results first: they can only belong to items already taken
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt_o <= result_cnt_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result byte %h kind %b last %b", $time,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want != {m_axis_tdata, m_axis_tuser, m_axis_tlast}) begin
            $display("%0t: result mismatch, expected byte %h kind %b last %b, got %h %b %b",
                     $time, want.data, want.kind, want.last, m_axis_tdata,
                     m_axis_tuser, m_axis_tlast);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) echo_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) edit_byte(s_axis_tdata);
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- dv/ansi_terminal_line_editor_test.sv -----
`timescale 1ns / 100ps

module ansi_terminal_line_editor_test;
  import ate_pkg::*;

  localparam int LINE_LEN = 32;
  localparam int IDLE_LIMIT = 4000;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_data_i;
  int         err_cnt;
  int         pending;
  int         result_cnt;
  int         byte_cnt;
  int         quiet_cycles;
  int         stall_left;
  logic       stall_en;

  ansi_terminal_line_editor #(.LINE_LEN(LINE_LEN)) dut (.*);

  ansi_terminal_line_editor_checker #(.LINE_LEN(LINE_LEN)) u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .err_cnt_o(err_cnt), .pending_o(pending), .result_cnt_o(result_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // receiver stalls: mostly short, now and then a long one; off for stretches
  always @(negedge clk_i) begin
    if (!stall_en) begin
      m_axis_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(10, 40);
    end else begin
      m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // idle watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("ansi_terminal_line_editor_test: done, errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    repeat (gap_len()) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    byte_cnt++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // wait for all results, then for the editor to finish silent work
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (2 * LINE_LEN + 30) @(negedge clk_i);
  endtask

  task automatic set_echo(input logic v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random byte, weighted toward editing keys and well-formed sequences
  task automatic random_key();
    int sel;
    logic [7:0] fins [5];
    fins = '{CH_UP_C, CH_UP_D, CH_UP_H, CH_UP_F, CH_TILDE};
    sel = $urandom_range(0, 19);
    if (sel < 9) send_byte(8'($urandom_range(32, 126)));
    else if (sel < 11) send_byte(CH_DEL);
    else if (sel < 16) begin
      send_byte(CH_ESC);
      send_byte(CH_LBRK);
      if ($urandom_range(0, 2) != 0) begin
        repeat ($urandom_range(1, 2)) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 4) == 0) begin
          send_byte(CH_SEMI);
          send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end
      send_byte(fins[$urandom_range(0, 4)]);
    end else if (sel < 17) send_byte(CH_CR);
    else send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    m_axis_tready = 1'b1;
    stall_en = 1'b0;
    byte_cnt = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: insert, moves, edits, odd sequences, full line
    send_str("ab~ ");
    send_byte(CH_TILDE);
    send_str("\033[2D");
    send_byte(8'h7e);
    send_str("\033[D\033[0C\033[C\033[9C");
    send_str("\033[H\033[H\033[F\033[F\033[3D\033[~\033[1;5F");
    send_str("\033x\033[999D\033[5q");
    send_str("\033[2\r");
    send_byte(CH_DEL);
    send_byte(8'h09);
    send_byte(8'hff);
    send_byte(8'h80);
    send_byte(CH_CR);
    stall_en = 1'b1;
    repeat (LINE_LEN + 2) send_byte(8'($urandom_range(32, 126)));
    send_str("\033[H");
    send_byte(CH_DEL);
    send_byte(CH_CR);
    send_byte(CH_CR);

    // random phases with the echo toggled
    for (int ph = 0; ph < 4; ph++) begin
      set_echo(ph[0]);
      stall_en = (ph != 2);
      repeat (8) random_key();
    end
    set_echo(1'b1);
    send_byte(CH_CR);
    drain();

    $display("covered %0d received bytes and %0d result bytes, echo on and off",
             byte_cnt, result_cnt);
    if (err_cnt == 0) $display("ansi_terminal_line_editor_test: done, clean");
    else $display("ansi_terminal_line_editor_test: done, errors");
    $finish;
  end

endmodule
